### rtl/syrk_pkg.sv
`timescale 1ns / 1ps
package syrk_pkg;

   // Matrix geometry
   localparam int MAX_DIM = 16;
   localparam int IDX_W   = 4;
   localparam int DIM_W   = 5;
   localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
   localparam int DEPTH   = MAX_DIM * MAX_DIM;

   // Number formats
   localparam int A_W        = 16;
   localparam int C_W        = 32;
   localparam int GAIN_W     = 16;
   localparam int PROD_W     = 2 * A_W;
   localparam int ACC_W      = PROD_W + $clog2(MAX_DIM);
   localparam int ALPHA_P_W  = GAIN_W + ACC_W;
   localparam int BETA_P_W   = GAIN_W + C_W;
   localparam int SUM_W      = ALPHA_P_W + 1;
   localparam int FRAC_SHIFT = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_C = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_READ_C  = 2'd3
   } syrk_op_type;

   typedef enum logic {
      KIND_DONE = 1'b0,
      KIND_READ = 1'b1
   } syrk_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRIANGLE_UPPER = 3'd0,
      CSR_TRANSPOSE_MODE = 3'd1,
      CSR_ORDER          = 3'd2,
      CSR_INNER_DEPTH    = 3'd3,
      CSR_ALPHA_GAIN     = 3'd4,
      CSR_BETA_GAIN      = 3'd5
   } syrk_csr_type;

   typedef struct packed {
      syrk_op_type             req_type;
      logic [IDX_W-1:0]        row_index;
      logic [IDX_W-1:0]        col_index;
      logic signed [C_W-1:0]   elem_value;
   } syrk_req_type;

   typedef struct packed {
      syrk_kind_type           result_kind;
      logic signed [C_W-1:0]   result_value;
   } syrk_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic              a_wr;
      logic              c_wr;
      logic [ADDR_W-1:0] wr_addr;
      logic [C_W-1:0]    wr_data;
      logic              c_rd;
      logic [ADDR_W-1:0] c_rd_addr;
      logic              mac;
      logic              mac_first;
      logic [ADDR_W-1:0] a0_addr;
      logic [ADDR_W-1:0] a1_addr;
      logic              fin;
      logic              fin_zero;
      logic              load_read;
      logic              read_zero;
      logic              load_done;
   } syrk_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic elem_done;
      logic slot_free;
   } syrk_status_type;

   function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
   endfunction

   function automatic logic in_range(input logic [IDX_W-1:0] row,
                                     input logic [IDX_W-1:0] col);
      return (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
   endfunction

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] d);
      return (32'(d) > MAX_DIM) ? DIM_W'(MAX_DIM) : d;
   endfunction

endpackage

### rtl/syrk_ram.sv
`timescale 1ns / 1ps
module syrk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/syrk_ctrl.sv
`timescale 1ns / 1ps
module syrk_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  syrk_pkg::syrk_req_type         req_data,
   input  logic                           triangle_upper,
   input  logic                           transpose_mode,
   input  logic [syrk_pkg::DIM_W-1:0]     order,
   input  logic [syrk_pkg::DIM_W-1:0]     inner_depth,
   output syrk_pkg::syrk_cmd_type         cmd,
   input  syrk_pkg::syrk_status_type      status
);
   import syrk_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_READ = 6'b000010,
      ST_MAC  = 6'b000100,
      ST_FIN  = 6'b001000,
      ST_WAIT = 6'b010000,
      ST_DONE = 6'b100000
   } syrk_state_type;

   syrk_state_type   state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] l_ff, l_in;
   logic [IDX_W-1:0] n_last_ff, n_last_in;
   logic [IDX_W-1:0] k_last_ff, k_last_in;
   logic             k_zero_ff, k_zero_in;
   logic             read_ok_ff, read_ok_in;

   logic [DIM_W-1:0]  n_sat, k_sat;
   logic [ADDR_W-1:0] req_addr;
   logic              req_ok;
   logic              accept;
   logic              last_elem;

   assign n_sat    = sat_dim(order);
   assign k_sat    = sat_dim(inner_depth);
   assign req_addr = elem_addr(req_data.row_index, req_data.col_index);
   assign req_ok   = in_range(req_data.row_index, req_data.col_index);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept   = req_valid && req_ready;

   // Upper walks i = 0..j, lower walks i = j..n-1, both column by column
   assign last_elem = (j_ff == n_last_ff) &&
                      (triangle_upper ? (i_ff == j_ff) : (i_ff == n_last_ff));

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      l_in       = l_ff;
      n_last_in  = n_last_ff;
      k_last_in  = k_last_ff;
      k_zero_in  = k_zero_ff;
      read_ok_in = read_ok_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  OP_WRITE_A: begin
                     cmd.a_wr    = req_ok;
                     cmd.wr_addr = req_addr;
                     cmd.wr_data = req_data.elem_value;
                  end
                  OP_WRITE_C: begin
                     cmd.c_wr    = req_ok;
                     cmd.wr_addr = req_addr;
                     cmd.wr_data = req_data.elem_value;
                  end
                  OP_READ_C: begin
                     cmd.c_rd      = 1'b1;
                     cmd.c_rd_addr = req_addr;
                     read_ok_in    = req_ok;
                     state_in      = ST_READ;
                  end
                  OP_COMPUTE: begin
                     i_in      = '0;
                     j_in      = '0;
                     l_in      = '0;
                     n_last_in = IDX_W'(n_sat - DIM_W'(1));
                     k_last_in = IDX_W'(k_sat - DIM_W'(1));
                     k_zero_in = (k_sat == '0);
                     if (n_sat == '0) begin
                        state_in = ST_DONE;
                     end else if (k_sat == '0) begin
                        state_in = ST_FIN;
                     end else begin
                        state_in = ST_MAC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (status.slot_free) begin
               cmd.load_read = 1'b1;
               cmd.read_zero = !read_ok_ff;
               state_in      = ST_IDLE;
            end
         end
         ST_MAC: begin
            cmd.mac       = 1'b1;
            cmd.mac_first = (l_ff == '0);
            cmd.a0_addr   = transpose_mode ? elem_addr(l_ff, i_ff) : elem_addr(i_ff, l_ff);
            cmd.a1_addr   = transpose_mode ? elem_addr(l_ff, j_ff) : elem_addr(j_ff, l_ff);
            if (l_ff == k_last_ff) begin
               l_in     = '0;
               state_in = ST_FIN;
            end else begin
               l_in = l_ff + IDX_W'(1);
            end
         end
         ST_FIN: begin
            cmd.c_rd      = 1'b1;
            cmd.c_rd_addr = elem_addr(i_ff, j_ff);
            cmd.fin       = 1'b1;
            cmd.fin_zero  = k_zero_ff;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.elem_done) begin
               if (last_elem) begin
                  state_in = ST_DONE;
               end else begin
                  if (triangle_upper) begin
                     if (i_ff == j_ff) begin
                        j_in = j_ff + IDX_W'(1);
                        i_in = '0;
                     end else begin
                        i_in = i_ff + IDX_W'(1);
                     end
                  end else begin
                     if (i_ff == n_last_ff) begin
                        j_in = j_ff + IDX_W'(1);
                        i_in = j_ff + IDX_W'(1);
                     end else begin
                        i_in = i_ff + IDX_W'(1);
                     end
                  end
                  state_in = k_zero_ff ? ST_FIN : ST_MAC;
               end
            end
         end
         ST_DONE: begin
            if (status.slot_free) begin
               cmd.load_done = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      l_ff       <= l_in;
      n_last_ff  <= n_last_in;
      k_last_ff  <= k_last_in;
      k_zero_ff  <= k_zero_in;
      read_ok_ff <= read_ok_in;
   end

endmodule

### rtl/syrk_dp.sv
`timescale 1ns / 1ps
module syrk_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [syrk_pkg::GAIN_W-1:0] alpha_gain,
   input  logic signed [syrk_pkg::GAIN_W-1:0] beta_gain,
   input  syrk_pkg::syrk_cmd_type            cmd,
   output syrk_pkg::syrk_status_type         status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output syrk_pkg::syrk_rsp_type            rsp_data
);
   import syrk_pkg::*;

   logic [A_W-1:0]    a0_q, a1_q;
   logic [C_W-1:0]    c_q;
   logic signed [A_W-1:0] a0_s, a1_s;
   logic signed [C_W-1:0] c_s;

   // Pipeline control
   logic mac_v1_ff, mac_v2_ff, first1_ff, first2_ff;
   logic fin_v1_ff, fin_v2_ff, fin_v3_ff, fin_v4_ff;
   logic zero1_ff, zero2_ff;
   logic [ADDR_W-1:0] wb_addr1_ff, wb_addr2_ff, wb_addr3_ff, wb_addr4_ff;

   // Arithmetic
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in, acc_eff;
   logic signed [ALPHA_P_W-1:0] alpha_prod_ff, alpha_prod_in;
   logic signed [BETA_P_W-1:0]  beta_prod_ff, beta_prod_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in, shifted;
   logic [SUM_W-C_W:0]          sum_hi;
   logic [C_W-1:0]              wb_value;

   // Response slot
   logic                  rsp_valid_ff, rsp_valid_in;
   syrk_kind_type         rsp_kind_ff, rsp_kind_in;
   logic signed [C_W-1:0] rsp_value_ff, rsp_value_in;

   logic              c_wr_en;
   logic [ADDR_W-1:0] c_wr_addr;
   logic [C_W-1:0]    c_wr_data;

   // Two copies of A give both operands of a product in the same cycle
   syrk_ram #(.WIDTH(A_W), .DEPTH(DEPTH)) u_a0_ram (
      .clock   (clock),
      .wr_en   (cmd.a_wr),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_data[A_W-1:0]),
      .rd_en   (cmd.mac),
      .rd_addr (cmd.a0_addr),
      .rd_data (a0_q)
   );

   syrk_ram #(.WIDTH(A_W), .DEPTH(DEPTH)) u_a1_ram (
      .clock   (clock),
      .wr_en   (cmd.a_wr),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_data[A_W-1:0]),
      .rd_en   (cmd.mac),
      .rd_addr (cmd.a1_addr),
      .rd_data (a1_q)
   );

   // Host writes and write-back never meet: host writes only while idle
   assign c_wr_en   = cmd.c_wr || fin_v4_ff;
   assign c_wr_addr = fin_v4_ff ? wb_addr4_ff : cmd.wr_addr;
   assign c_wr_data = fin_v4_ff ? wb_value : cmd.wr_data;

   syrk_ram #(.WIDTH(C_W), .DEPTH(DEPTH)) u_c_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_en   (cmd.c_rd),
      .rd_addr (cmd.c_rd_addr),
      .rd_data (c_q)
   );

   assign a0_s = a0_q;
   assign a1_s = a1_q;
   assign c_s  = c_q;

   assign prod_in = PROD_W'(a0_s) * PROD_W'(a1_s);
   assign acc_in  = first2_ff ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
   assign acc_eff = zero2_ff ? '0 : acc_ff;
   assign alpha_prod_in = ALPHA_P_W'(alpha_gain) * ALPHA_P_W'(acc_eff);
   // Zero beta must not touch old C at all
   assign beta_prod_in  = (beta_gain == '0) ? '0 :
                          BETA_P_W'(beta_gain) * BETA_P_W'(c_s);
   assign sum_in  = SUM_W'(alpha_prod_ff) + SUM_W'(beta_prod_ff);

   // Floor shift, then clamp to the 32-bit range
   assign shifted = sum_ff >>> FRAC_SHIFT;
   assign sum_hi  = shifted[SUM_W-1:C_W-1];
   always_comb begin
      if ((&sum_hi) || !(|sum_hi)) begin
         wb_value = shifted[C_W-1:0];
      end else if (shifted[SUM_W-1]) begin
         wb_value = {1'b1, {(C_W-1){1'b0}}};
      end else begin
         wb_value = {1'b0, {(C_W-1){1'b1}}};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      if (cmd.load_read) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_READ;
         rsp_value_in = cmd.read_zero ? '0 : c_s;
      end else if (cmd.load_done) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_DONE;
         rsp_value_in = '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_v1_ff    <= 1'b0;
         mac_v2_ff    <= 1'b0;
         fin_v1_ff    <= 1'b0;
         fin_v2_ff    <= 1'b0;
         fin_v3_ff    <= 1'b0;
         fin_v4_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mac_v1_ff    <= cmd.mac;
         mac_v2_ff    <= mac_v1_ff;
         fin_v1_ff    <= cmd.fin;
         fin_v2_ff    <= fin_v1_ff;
         fin_v3_ff    <= fin_v2_ff;
         fin_v4_ff    <= fin_v3_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff    <= cmd.mac_first;
      first2_ff    <= first1_ff;
      zero1_ff     <= cmd.fin_zero;
      zero2_ff     <= zero1_ff;
      wb_addr1_ff  <= cmd.c_rd_addr;
      wb_addr2_ff  <= wb_addr1_ff;
      wb_addr3_ff  <= wb_addr2_ff;
      wb_addr4_ff  <= wb_addr3_ff;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      if (mac_v1_ff) begin
         prod_ff <= prod_in;
      end
      if (mac_v2_ff) begin
         acc_ff <= acc_in;
      end
      if (fin_v1_ff) begin
         beta_prod_ff <= beta_prod_in;
      end
      if (fin_v2_ff) begin
         alpha_prod_ff <= alpha_prod_in;
      end
      if (fin_v3_ff) begin
         sum_ff <= sum_in;
      end
   end

   assign status.elem_done = fin_v4_ff;
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.result_kind  = rsp_kind_ff;
   assign rsp_data.result_value = rsp_value_ff;

endmodule

### rtl/symmetric_rank_k_update.sv
`timescale 1ns / 1ps
// Channel   Ports                          Moves
// -------   -----------------------------  ------------------------------------------
// request   req_valid/req_ready/req_data   write A, write C, compute, read C
// response  rsp_valid/rsp_ready/rsp_data   compute done (value 0) or C read data
// config    csr_we/csr_index/csr_wdata     register write, no wait, no read-back
//
// Element writes go straight into memory. A C read passes the C memory's registered
// read, then the response register. A compute handles each updated element with
// k multiply-accumulate steps through the two A memory ports, one step that fetches
// old C, then the scale and write-back pipeline, for n(n+1)/2 elements, and ends with
// the done response. Synchronous reset restores register defaults and clears control;
// the memories keep their contents. A stalled response holds its register; element
// writes are still accepted meanwhile, while reads and computes wait for the slot.
module symmetric_rank_k_update (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  syrk_pkg::syrk_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output syrk_pkg::syrk_rsp_type              rsp_data,
   input  logic                                csr_we,
   input  logic [syrk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [syrk_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import syrk_pkg::*;

   // Configuration registers
   logic                     triangle_upper_ff, triangle_upper_in;
   logic                     transpose_mode_ff, transpose_mode_in;
   logic [DIM_W-1:0]         order_ff, order_in;
   logic [DIM_W-1:0]         inner_depth_ff, inner_depth_in;
   logic signed [GAIN_W-1:0] alpha_gain_ff, alpha_gain_in;
   logic signed [GAIN_W-1:0] beta_gain_ff, beta_gain_in;

   syrk_cmd_type    cmd;
   syrk_status_type status;

   // Decode the register write; unknown indexes drop the write
   always_comb begin
      triangle_upper_in = triangle_upper_ff;
      transpose_mode_in = transpose_mode_ff;
      order_in          = order_ff;
      inner_depth_in    = inner_depth_ff;
      alpha_gain_in     = alpha_gain_ff;
      beta_gain_in      = beta_gain_ff;
      if (csr_we) begin
         case (syrk_csr_type'(csr_index))
            CSR_TRIANGLE_UPPER: triangle_upper_in = csr_wdata[0];
            CSR_TRANSPOSE_MODE: transpose_mode_in = csr_wdata[0];
            CSR_ORDER:          order_in          = csr_wdata[DIM_W-1:0];
            CSR_INNER_DEPTH:    inner_depth_in    = csr_wdata[DIM_W-1:0];
            CSR_ALPHA_GAIN:     alpha_gain_in     = csr_wdata[GAIN_W-1:0];
            CSR_BETA_GAIN:      beta_gain_in      = csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Defaults: upper triangle, no transpose, empty sizes, alpha 1.0, beta 0
   always_ff @(posedge clock) begin
      if (reset) begin
         triangle_upper_ff <= 1'b1;
         transpose_mode_ff <= 1'b0;
         order_ff          <= '0;
         inner_depth_ff    <= '0;
         alpha_gain_ff     <= GAIN_W'(256);
         beta_gain_ff      <= '0;
      end else begin
         triangle_upper_ff <= triangle_upper_in;
         transpose_mode_ff <= transpose_mode_in;
         order_ff          <= order_in;
         inner_depth_ff    <= inner_depth_in;
         alpha_gain_ff     <= alpha_gain_in;
         beta_gain_ff      <= beta_gain_in;
      end
   end

   // Sequence requests and walk the triangle
   syrk_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .triangle_upper (triangle_upper_ff),
      .transpose_mode (transpose_mode_ff),
      .order          (order_ff),
      .inner_depth    (inner_depth_ff),
      .cmd            (cmd),
      .status         (status)
   );

   // Hold the matrices, run the multiply-accumulate and scale pipeline,
   // and own the response register
   syrk_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .alpha_gain (alpha_gain_ff),
      .beta_gain  (beta_gain_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### rtl/syrk_checker.sv
`timescale 1ns / 1ps
module syrk_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input syrk_pkg::syrk_req_type          req_data,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input syrk_pkg::syrk_rsp_type          rsp_data,
   input logic                            csr_we,
   input logic [syrk_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [syrk_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import syrk_pkg::*;

   // Stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Compute completion carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.result_kind == KIND_DONE) |-> (rsp_data.result_value == '0))
      else $error("compute done with nonzero value");

   // A read or compute occupies the block for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      ((req_data.req_type == OP_READ_C) || (req_data.req_type == OP_COMPUTE))
      |=> !req_ready)
      else $error("request accepted while read or compute in flight");

   // Reset leaves no response pending
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind symmetric_rank_k_update syrk_checker u_syrk_checker (.*);
